// ----- rtl/gcc_pkg.sv -----
`timescale 1ns / 1ps

package gcc_pkg;

    // Input word: one sensor sample
    typedef struct packed {
        logic [31:0]       now_ms;
        logic signed [7:0] temperature;
        logic [6:0]        soil_moisture;
        logic [6:0]        air_moisture;
        logic [9:0]        light_level;
    } in_t;

    // Output word: drive bits and minute of day
    typedef struct packed {
        logic        heater_drive;
        logic        pump_drive;
        logic        fan_drive;
        logic        lamp_drive;
        logic [10:0] minute_of_day;
    } out_t;

    typedef struct packed {
        logic signed [7:0] target_temperature;
        logic [6:0]        target_soil_moisture;
        logic [6:0]        target_air_moisture;
        logic [9:0]        target_light;
        logic [10:0]       day_start_minute;
        logic [10:0]       day_end_minute;
        logic              planned_airing;
    } cfg_t;

    // Regulator state as seen after one sample
    typedef struct packed {
        logic heater;
        logic pump;
        logic fan_heat_request;
    } loop_state_t;

    // Bits that ride along the minute pipeline
    typedef struct packed {
        logic heater;
        logic pump;
        logic fan;
        logic light_ok;
    } side_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_TEMPERATURE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_SOIL_MOISTURE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_AIR_MOISTURE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_LIGHT         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DAY_START_MINUTE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DAY_END_MINUTE       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANNED_AIRING       = 3'd6;

    localparam logic signed [7:0] RST_TARGET_TEMPERATURE = 8'sd24;
    localparam logic [6:0]  RST_TARGET_SOIL_MOISTURE = 7'd50;
    localparam logic [6:0]  RST_TARGET_AIR_MOISTURE  = 7'd70;
    localparam logic [9:0]  RST_TARGET_LIGHT         = 10'd512;
    localparam logic [10:0] RST_DAY_START_MINUTE     = 11'd480;
    localparam logic [10:0] RST_DAY_END_MINUTE       = 11'd1200;

    localparam logic [31:0]       LOCKOUT_MS = 32'd1000;
    localparam logic signed [8:0] TEMP_BAND  = 9'sd2;
    localparam logic [7:0]        SOIL_BAND  = 8'd5;

    // ms / 60000 = (ms >> 5) / 1875, done as multiply by ceil(2^38 / 1875)
    localparam logic [27:0] MS_RECIP       = 28'd146601551;
    localparam int          MS_RECIP_SHIFT = 38;
    // (q >> 5) / 45, multiply by ceil(2^18 / 45)
    localparam logic [12:0] DAY_RECIP       = 13'd5826;
    localparam int          DAY_RECIP_SHIFT = 18;
    localparam logic [10:0] MINUTES_PER_DAY = 11'd1440;

endpackage

// ----- rtl/greenhouse_climate_controller.sv -----
`timescale 1ns / 1ps

// Climate regulator for one greenhouse bay. Each input word is a sensor sample
// stamped with a free-running millisecond clock; each yields exactly one output
// word with the heater, pump, fan and lamp drive bits and the minute of day.
// One sample is accepted per clock unless a stalled output fills every stage. Once a
// sample is in the input register, its result word is built in steps: the first step
// runs the heater/pump regulators and the first constant multiplication of the
// millisecond stamp, the second does the day multiplication, and the third strips
// whole days and loads the output register with the lamp bit and minute. Up to four
// samples are in flight, and input stays ready as long as any stage is free. The config
// port is always ready and must be written only while no sample is in flight.
module greenhouse_climate_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  gcc_pkg::in_t                       in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output gcc_pkg::out_t                      out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gcc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    gcc_pkg::cfg_t        cfg;
    gcc_pkg::loop_state_t state_next;

    logic va_reg, va_next;
    logic vb_reg, vb_next;
    logic vc_reg, vc_next;
    logic vo_reg, vo_next;

    gcc_pkg::in_t  item_a_reg;
    gcc_pkg::side_t side_b_reg;
    gcc_pkg::side_t side_c_reg;
    gcc_pkg::side_t side_a;
    gcc_pkg::out_t out_reg;
    gcc_pkg::out_t out_next;

    logic        rdy_o, rdy_c, rdy_b;
    logic        mv_a, mv_b, mv_c;
    logic        in_fire;
    logic [10:0] minute;
    logic        lamp;

    // each stage takes a word when empty or when its word moves on
    assign rdy_o    = !vo_reg || out_ready;
    assign rdy_c    = !vc_reg || rdy_o;
    assign rdy_b    = !vb_reg || rdy_c;
    assign in_ready = !va_reg || rdy_b;
    assign in_fire  = in_valid && in_ready;
    assign mv_a     = va_reg && rdy_b;
    assign mv_b     = vb_reg && rdy_c;
    assign mv_c     = vc_reg && rdy_o;

    gcc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gcc_loop u_loop (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (mv_a),
        .item       (item_a_reg),
        .cfg        (cfg),
        .state_next (state_next)
    );

    gcc_minute u_minute (
        .clk    (clk),
        .ld_b   (mv_a),
        .ld_c   (mv_b),
        .now_ms (item_a_reg.now_ms),
        .minute (minute)
    );

    assign side_a.heater   = state_next.heater;
    assign side_a.pump     = state_next.pump;
    assign side_a.fan      = cfg.planned_airing
                           || (item_a_reg.air_moisture >= cfg.target_air_moisture)
                           || state_next.fan_heat_request;
    assign side_a.light_ok = item_a_reg.light_level >= cfg.target_light;

    assign lamp = side_c_reg.light_ok
               && (minute >= cfg.day_start_minute)
               && (minute < cfg.day_end_minute);

    always_comb
    begin
        out_next.heater_drive  = side_c_reg.heater;
        out_next.pump_drive    = side_c_reg.pump;
        out_next.fan_drive     = side_c_reg.fan;
        out_next.lamp_drive    = lamp;
        out_next.minute_of_day = minute;
    end

    always_comb
    begin
        va_next = va_reg;
        if (in_fire)
            va_next = 1'b1;
        else if (mv_a)
            va_next = 1'b0;

        vb_next = vb_reg;
        if (mv_a)
            vb_next = 1'b1;
        else if (mv_b)
            vb_next = 1'b0;

        vc_next = vc_reg;
        if (mv_b)
            vc_next = 1'b1;
        else if (mv_c)
            vc_next = 1'b0;

        vo_next = vo_reg;
        if (mv_c)
            vo_next = 1'b1;
        else if (out_ready)
            vo_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vc_reg <= vc_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_a_reg <= in_data;
        if (mv_a)
            side_b_reg <= side_a;
        if (mv_b)
            side_c_reg <= side_b_reg;
        if (mv_c)
            out_reg <= out_next;
    end

    assign out_valid = vo_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/gcc_cfg.sv -----
`timescale 1ns / 1ps

module gcc_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gcc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output gcc_pkg::cfg_t                      cfg
);

    gcc_pkg::cfg_t cfg_reg;
    gcc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                gcc_pkg::REG_TARGET_TEMPERATURE:
                    cfg_next.target_temperature = $signed(cfg_data[7:0]);
                gcc_pkg::REG_TARGET_SOIL_MOISTURE:
                    cfg_next.target_soil_moisture = cfg_data[6:0];
                gcc_pkg::REG_TARGET_AIR_MOISTURE:
                    cfg_next.target_air_moisture = cfg_data[6:0];
                gcc_pkg::REG_TARGET_LIGHT:
                    cfg_next.target_light = cfg_data[9:0];
                gcc_pkg::REG_DAY_START_MINUTE:
                    cfg_next.day_start_minute = cfg_data;
                gcc_pkg::REG_DAY_END_MINUTE:
                    cfg_next.day_end_minute = cfg_data;
                gcc_pkg::REG_PLANNED_AIRING:
                    cfg_next.planned_airing = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_temperature   <= gcc_pkg::RST_TARGET_TEMPERATURE;
            cfg_reg.target_soil_moisture <= gcc_pkg::RST_TARGET_SOIL_MOISTURE;
            cfg_reg.target_air_moisture  <= gcc_pkg::RST_TARGET_AIR_MOISTURE;
            cfg_reg.target_light         <= gcc_pkg::RST_TARGET_LIGHT;
            cfg_reg.day_start_minute     <= gcc_pkg::RST_DAY_START_MINUTE;
            cfg_reg.day_end_minute       <= gcc_pkg::RST_DAY_END_MINUTE;
            cfg_reg.planned_airing       <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/gcc_loop.sv -----
`timescale 1ns / 1ps

module gcc_loop (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 upd,
    input  gcc_pkg::in_t         item,
    input  gcc_pkg::cfg_t        cfg,
    output gcc_pkg::loop_state_t state_next
);

    logic        heater_reg, heater_next;
    logic        pump_reg, pump_next;
    logic        fan_req_reg, fan_req_next;
    logic [31:0] heater_tog_reg, heater_tog_next;
    logic [31:0] pump_tog_reg, pump_tog_next;

    logic [31:0]       heater_elapsed;
    logic [31:0]       pump_elapsed;
    logic              heater_open;
    logic              pump_open;
    logic signed [8:0] temp_s;
    logic signed [8:0] tgt_s;
    logic              temp_low;
    logic              temp_high;
    logic [7:0]        soil_u;
    logic [7:0]        soil_tgt_u;
    logic              soil_low;
    logic              soil_high;

    // elapsed time wraps with the ms clock
    assign heater_elapsed = item.now_ms - heater_tog_reg;
    assign pump_elapsed   = item.now_ms - pump_tog_reg;
    assign heater_open    = heater_elapsed > gcc_pkg::LOCKOUT_MS;
    assign pump_open      = pump_elapsed > gcc_pkg::LOCKOUT_MS;

    // band edges computed one bit wider than the inputs so nothing wraps
    assign temp_s    = {item.temperature[7], item.temperature};
    assign tgt_s     = {cfg.target_temperature[7], cfg.target_temperature};
    assign temp_low  = (temp_s + gcc_pkg::TEMP_BAND) < tgt_s;
    assign temp_high = temp_s > (tgt_s + gcc_pkg::TEMP_BAND);

    assign soil_u     = {1'b0, item.soil_moisture};
    assign soil_tgt_u = {1'b0, cfg.target_soil_moisture};
    assign soil_low   = (soil_u + gcc_pkg::SOIL_BAND) < soil_tgt_u;
    assign soil_high  = soil_u > (soil_tgt_u + gcc_pkg::SOIL_BAND);

    always_comb
    begin
        heater_next     = heater_reg;
        pump_next       = pump_reg;
        fan_req_next    = fan_req_reg;
        heater_tog_next = heater_tog_reg;
        pump_tog_next   = pump_tog_reg;

        if (heater_open)
        begin
            if (temp_low && !pump_reg)
            begin
                heater_next     = 1'b1;
                fan_req_next    = 1'b1;
                heater_tog_next = item.now_ms;
            end
            else if (temp_high)
            begin
                heater_next     = 1'b0;
                fan_req_next    = 1'b1;
                heater_tog_next = item.now_ms;
            end
            else
            begin
                fan_req_next = 1'b0;
            end
        end

        // pump wins: starting it shuts the heater without touching its timer
        if (pump_open)
        begin
            if (soil_low)
            begin
                heater_next   = 1'b0;
                pump_next     = 1'b1;
                pump_tog_next = item.now_ms;
            end
            else if (soil_high)
            begin
                pump_next     = 1'b0;
                pump_tog_next = item.now_ms;
            end
        end
    end

    assign state_next.heater           = heater_next;
    assign state_next.pump             = pump_next;
    assign state_next.fan_heat_request = fan_req_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heater_reg     <= 1'b0;
            pump_reg       <= 1'b0;
            fan_req_reg    <= 1'b0;
            heater_tog_reg <= '0;
            pump_tog_reg   <= '0;
        end
        else if (upd)
        begin
            heater_reg     <= heater_next;
            pump_reg       <= pump_next;
            fan_req_reg    <= fan_req_next;
            heater_tog_reg <= heater_tog_next;
            pump_tog_reg   <= pump_tog_next;
        end
    end

endmodule

// ----- rtl/gcc_minute.sv -----
`timescale 1ns / 1ps

module gcc_minute (
    input  logic        clk,
    input  logic        ld_b,
    input  logic        ld_c,
    input  logic [31:0] now_ms,
    output logic [10:0] minute
);

    logic [54:0] prod1_reg, prod1_next;
    logic [16:0] q_b;
    logic [16:0] q_reg;
    logic [24:0] prod2_reg, prod2_next;
    logic [6:0]  days;
    logic [16:0] day_base;
    logic [16:0] rem;

    // stage B: total minutes since clock zero
    assign prod1_next = 55'(now_ms[31:5]) * 55'(gcc_pkg::MS_RECIP);
    assign q_b        = prod1_reg[54:gcc_pkg::MS_RECIP_SHIFT];
    assign prod2_next = 25'(q_b[16:5]) * 25'(gcc_pkg::DAY_RECIP);

    // stage C: strip whole days
    assign days     = prod2_reg[24:gcc_pkg::DAY_RECIP_SHIFT];
    assign day_base = 17'(days) * 17'(gcc_pkg::MINUTES_PER_DAY);
    assign rem      = q_reg - day_base;
    assign minute   = rem[10:0];

    always_ff @(posedge clk)
    begin
        if (ld_b)
        begin
            prod1_reg <= prod1_next;
        end
        if (ld_c)
        begin
            q_reg     <= q_b;
            prod2_reg <= prod2_next;
        end
    end

endmodule

// ----- rtl/gcc_checker.sv -----
`timescale 1ns / 1ps

module gcc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input gcc_pkg::out_t out_data
);

    logic [2:0] inflight_reg, inflight_next;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_fire && !out_fire)
            inflight_next = inflight_reg + 3'd1;
        else if (out_fire && !in_fire)
            inflight_next = inflight_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // no word delivered without a sample behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> (inflight_reg != 3'd0))
        else $error("output word without pending sample");

    // four pipeline slots at most
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd4)
        else $error("more samples in flight than stages");

    a_heat_pump_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.heater_drive && out_data.pump_drive))
        else $error("heater and pump driven together");

    a_minute_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.minute_of_day < 11'd1440))
        else $error("minute of day out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled output word changed");

endmodule

bind greenhouse_climate_controller gcc_checker u_gcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
